// ===== sv/ssms_pkg.sv =====
package ssms_pkg;

    localparam int SECTOR_WORDS    = 64;
    localparam int WORD_BYTES      = 8;
    localparam int SECTOR_BYTES    = SECTOR_WORDS * WORD_BYTES;
    localparam int IDX_W           = 10;
    localparam int PATTERN_SECTORS = 1 << IDX_W;
    localparam int WORD_W          = 64;
    localparam int WCNT_W          = $clog2(SECTOR_WORDS + 1);
    localparam int BYTES_W         = 10;
    localparam int SCORE_W         = 4;
    localparam int PROD_W          = BYTES_W + SCORE_W;

    localparam logic [SCORE_W-1:0] SCORE_FULL = SCORE_W'(10);
    localparam logic [SCORE_W-1:0] SCORE_ZERO = '0;

    typedef enum logic {
        OP_COMPARE = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    // one accepted item after the run tracker
    typedef struct packed {
        logic              clear;
        logic              finish;
        logic [IDX_W-1:0]  idx;
        logic [WCNT_W-1:0] words;
        logic              saw_nonzero;
    } run_item_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [SCORE_W-1:0] data;
    } table_wr_t;

endpackage

// ===== sv/sector_suffix_match_scorer_unit.sv =====
// Sector suffix-match scorer. One word pair (or one clear item) is taken per cycle,
// back to back, while s_ready is high; a compare item with s_last_word set is captured
// in the input register when accepted, and its result is loaded from there into the
// output register unless the output stalls: the run counters update ahead of the input register, the score table
// read is registered alongside the item, and the score, max update and table write
// sit between the input register and the output register.
// The result register holds while m_ready is low and stalls intake only when a new
// result would have to replace one still waiting. After reset the score table is
// cleared one entry per cycle, so s_ready stays low until all 1024 entries are cleared.
module sector_suffix_match_scorer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [ssms_pkg::WORD_W-1:0]         s_disk_word,
    input  logic [ssms_pkg::WORD_W-1:0]         s_target_word,
    input  logic [ssms_pkg::IDX_W-1:0]          s_sector_index,
    input  logic                                s_last_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssms_pkg::IDX_W-1:0]          m_result_sector,
    output logic [ssms_pkg::BYTES_W-1:0]        m_match_bytes,
    output logic [ssms_pkg::SCORE_W-1:0]        m_score,
    output logic [ssms_pkg::SCORE_W-1:0]        m_best_score,
    output logic                                m_full_match
);

    logic                          accept;
    logic                          tbl_busy;
    ssms_pkg::run_item_t           run_item;
    ssms_pkg::run_item_t           s1_item_reg;
    logic                          s1_valid_reg;
    logic                          s1_adv;
    logic [ssms_pkg::SCORE_W-1:0]  stored;
    ssms_pkg::table_wr_t           tbl_wr;
    logic [ssms_pkg::BYTES_W-1:0]  bytes;
    logic [ssms_pkg::PROD_W-1:0]   prod;
    logic [ssms_pkg::PROD_W-1:0]   score_wide;
    logic [ssms_pkg::SCORE_W-1:0]  score;
    logic [ssms_pkg::SCORE_W-1:0]  best;
    logic                          m_valid_reg;
    logic [ssms_pkg::IDX_W-1:0]    m_sector_reg;
    logic [ssms_pkg::BYTES_W-1:0]  m_bytes_reg;
    logic [ssms_pkg::SCORE_W-1:0]  m_score_reg;
    logic [ssms_pkg::SCORE_W-1:0]  m_best_reg;

    assign s1_adv  = !s1_item_reg.finish || !m_valid_reg || m_ready;
    assign s_ready = !tbl_busy && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    ssms_run_tracker u_run (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .operation    (s_operation),
        .disk_word    (s_disk_word),
        .target_word  (s_target_word),
        .sector_index (s_sector_index),
        .last_word    (s_last_word),
        .item         (run_item)
    );

    ssms_score_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_sector_index),
        .rd_data (stored),
        .wr      (tbl_wr),
        .busy    (tbl_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= run_item;
        end
    end

    // score from the finished run; sector size is a power of two
    always_comb begin
        bytes = s1_item_reg.saw_nonzero
              ? ssms_pkg::BYTES_W'(s1_item_reg.words) * ssms_pkg::BYTES_W'(ssms_pkg::WORD_BYTES)
              : '0;
        prod       = ssms_pkg::PROD_W'(bytes) * ssms_pkg::PROD_W'(ssms_pkg::SCORE_FULL);
        score_wide = prod / ssms_pkg::PROD_W'(ssms_pkg::SECTOR_BYTES);
        score      = (score_wide > ssms_pkg::PROD_W'(ssms_pkg::SCORE_FULL))
                   ? ssms_pkg::SCORE_FULL : ssms_pkg::SCORE_W'(score_wide);
        best       = (score > stored) ? score : stored;

        tbl_wr.en   = s1_valid_reg && s1_adv && (s1_item_reg.clear || s1_item_reg.finish);
        tbl_wr.addr = s1_item_reg.idx;
        tbl_wr.data = s1_item_reg.clear ? ssms_pkg::SCORE_ZERO : best;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_item_reg.finish && s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_item_reg.finish && s1_adv) begin
            m_sector_reg <= s1_item_reg.idx;
            m_bytes_reg  <= bytes;
            m_score_reg  <= score;
            m_best_reg   <= best;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_sector = m_sector_reg;
    assign m_match_bytes   = m_bytes_reg;
    assign m_score         = m_score_reg;
    assign m_best_score    = m_best_reg;
    assign m_full_match    = (m_best_reg == ssms_pkg::SCORE_FULL);

    a_no_accept_while_clearing : assert property (
        @(posedge aclk) disable iff (!aresetn) tbl_busy |-> !s_ready
    ) else $error("item accepted during table clearing pass");

    a_best_not_below_score : assert property (
        @(posedge aclk) disable iff (!aresetn) m_valid |-> (m_best_score >= m_score)
    ) else $error("best score below current score");

    a_score_in_range : assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_best_score <= ssms_pkg::SCORE_FULL && m_score <= ssms_pkg::SCORE_FULL)
    ) else $error("score out of range");

    a_stage_held_on_stall : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_item_reg))
    ) else $error("pending item lost while result stage stalled");

endmodule

// ===== sv/ssms_run_tracker.sv =====
module ssms_run_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                operation,
    input  logic [ssms_pkg::WORD_W-1:0]         disk_word,
    input  logic [ssms_pkg::WORD_W-1:0]         target_word,
    input  logic [ssms_pkg::IDX_W-1:0]          sector_index,
    input  logic                                last_word,
    output ssms_pkg::run_item_t                 item
);

    logic                              still_reg, still_next;
    logic [ssms_pkg::WCNT_W-1:0]       words_reg, words_next;
    logic                              saw_reg, saw_next;
    logic [ssms_pkg::WCNT_W-1:0]       words_upd;
    logic                              saw_upd;
    logic                              is_cmp;

    always_comb begin
        is_cmp    = (ssms_pkg::op_t'(operation) == ssms_pkg::OP_COMPARE);
        words_upd = words_reg;
        saw_upd   = saw_reg;
        still_next = still_reg;
        if (is_cmp && still_reg) begin
            if (disk_word == target_word) begin
                // saturate on an overlong sector
                if (words_reg < ssms_pkg::WCNT_W'(ssms_pkg::SECTOR_WORDS)) begin
                    words_upd = words_reg + ssms_pkg::WCNT_W'(1);
                end
                if (target_word != '0) begin
                    saw_upd = 1'b1;
                end
            end else begin
                still_next = 1'b0;
            end
        end
        words_next = words_upd;
        saw_next   = saw_upd;
        if (is_cmp && last_word) begin
            still_next = 1'b1;
            words_next = '0;
            saw_next   = 1'b0;
        end

        item.clear       = !is_cmp;
        item.finish      = is_cmp && last_word;
        item.idx         = sector_index;
        item.words       = words_upd;
        item.saw_nonzero = saw_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_reg <= 1'b1;
            words_reg <= '0;
            saw_reg   <= 1'b0;
        end else if (accept) begin
            still_reg <= still_next;
            words_reg <= words_next;
            saw_reg   <= saw_next;
        end
    end

endmodule

// ===== sv/ssms_score_table.sv =====
module ssms_score_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [ssms_pkg::IDX_W-1:0]          rd_addr,
    output logic [ssms_pkg::SCORE_W-1:0]        rd_data,
    input  ssms_pkg::table_wr_t                 wr,
    output logic                                busy
);

    logic [ssms_pkg::SCORE_W-1:0] mem [ssms_pkg::PATTERN_SECTORS];
    logic                         clr_active_reg;
    logic [ssms_pkg::IDX_W-1:0]   clr_addr_reg;
    logic [ssms_pkg::SCORE_W-1:0] rdata_reg;
    logic                         we;
    logic [ssms_pkg::IDX_W-1:0]   waddr;
    logic [ssms_pkg::SCORE_W-1:0] wdata;

    always_comb begin
        we    = clr_active_reg || wr.en;
        waddr = clr_active_reg ? clr_addr_reg : wr.addr;
        wdata = clr_active_reg ? ssms_pkg::SCORE_ZERO : wr.data;
    end

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + ssms_pkg::IDX_W'(1);
            if (clr_addr_reg == ssms_pkg::IDX_W'(ssms_pkg::PATTERN_SECTORS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // forward a same-cycle write to the same entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rd_addr) begin
                rdata_reg <= wr.data;
            end else begin
                rdata_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rdata_reg;
    assign busy    = clr_active_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned MIN_SECTORS = 48;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned TAIL_CYCLES = 16;

    typedef struct {
        ssms_pkg::op_t                   operation;
        logic [ssms_pkg::WORD_W-1:0]     disk;
        logic [ssms_pkg::WORD_W-1:0]     pattern;
        logic [ssms_pkg::IDX_W-1:0]      idx;
        logic                            last;
    } word_pair_t;

    typedef struct {
        logic [ssms_pkg::IDX_W-1:0]   sector;
        logic [ssms_pkg::BYTES_W-1:0] bytes;
        logic [ssms_pkg::SCORE_W-1:0] score;
        logic [ssms_pkg::SCORE_W-1:0] best;
        logic                         full;
    } sector_score_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_operation = 1'b0;
    logic [ssms_pkg::WORD_W-1:0]    s_disk_word = '0;
    logic [ssms_pkg::WORD_W-1:0]    s_target_word = '0;
    logic [ssms_pkg::IDX_W-1:0]     s_sector_index = '0;
    logic                           s_last_word = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [ssms_pkg::IDX_W-1:0]     m_result_sector;
    logic [ssms_pkg::BYTES_W-1:0]   m_match_bytes;
    logic [ssms_pkg::SCORE_W-1:0]   m_score;
    logic [ssms_pkg::SCORE_W-1:0]   m_best_score;
    logic                           m_full_match;

    word_pair_t    word_pairs_to_send[$];
    sector_score_t pending_scores[$];
    word_pair_t    on_wire;
    sector_score_t want;

    // predictor state
    logic                         run_unbroken;
    int unsigned                  run_words;
    logic                         run_nonzero;
    logic [ssms_pkg::SCORE_W-1:0] best_by_sector[ssms_pkg::PATTERN_SECTORS];

    logic [ssms_pkg::IDX_W-1:0] hot_sectors[6];
    int unsigned items_queued = 0;
    int unsigned sectors_queued = 0;
    int unsigned pairs_sent = 0;
    int unsigned clears_sent = 0;
    int unsigned full_matches = 0;
    int unsigned results_checked = 0;
    int unsigned input_stalls = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned ready_hold = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    bit          long_hold_done = 1'b0;

    sector_suffix_match_scorer_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_disk_word     (s_disk_word),
        .s_target_word   (s_target_word),
        .s_sector_index  (s_sector_index),
        .s_last_word     (s_last_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_sector (m_result_sector),
        .m_match_bytes   (m_match_bytes),
        .m_score         (m_score),
        .m_best_score    (m_best_score),
        .m_full_match    (m_full_match)
    );

    always #4 aclk = ~aclk;

    function automatic logic [ssms_pkg::WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [ssms_pkg::IDX_W-1:0] pick_sector();
        if ($urandom_range(0, 9) < 7) return hot_sectors[$urandom_range(0, 5)];
        return ssms_pkg::IDX_W'($urandom());
    endfunction

    task automatic queue_pair(input ssms_pkg::op_t op,
                              input logic [ssms_pkg::WORD_W-1:0] dw,
                              input logic [ssms_pkg::WORD_W-1:0] pw,
                              input logic [ssms_pkg::IDX_W-1:0] idx,
                              input logic last);
        word_pair_t it;
        it.operation = op;
        it.disk = dw;
        it.pattern = pw;
        it.idx = idx;
        it.last = last;
        word_pairs_to_send.push_back(it);
        items_queued++;
        if (op == ssms_pkg::OP_COMPARE && last) sectors_queued++;
    endtask

    // one sector from its last word toward its first, with the first mismatch at cut
    task automatic queue_random_sector();
        int unsigned len;
        int unsigned cut;
        int unsigned roll;
        logic [ssms_pkg::IDX_W-1:0] idx;
        logic [ssms_pkg::WORD_W-1:0] w;
        logic [ssms_pkg::WORD_W-1:0] flip;
        bit zeros;
        roll = $urandom_range(0, 99);
        if (roll < 50) len = $urandom_range(1, 16);
        else if (roll < 75) len = $urandom_range(17, ssms_pkg::SECTOR_WORDS - 1);
        else if (roll < 90) len = ssms_pkg::SECTOR_WORDS;
        else len = $urandom_range(ssms_pkg::SECTOR_WORDS + 1, ssms_pkg::SECTOR_WORDS + 16);
        cut = ($urandom_range(0, 99) < 45) ? len : $urandom_range(0, len - 1);
        zeros = ($urandom_range(0, 9) == 0);
        idx = pick_sector();
        if ($urandom_range(0, 99) < 8) begin
            queue_pair(ssms_pkg::OP_CLEAR, rand_word(), rand_word(), idx, 1'($urandom()));
        end
        for (int unsigned k = 0; k < len; k++) begin
            w = (zeros || $urandom_range(0, 9) == 0) ? '0 : rand_word();
            if ($urandom_range(0, 1) == 0) begin
                flip = ssms_pkg::WORD_W'(1) << $urandom_range(0, ssms_pkg::WORD_W - 1);
            end else begin
                flip = rand_word() | ssms_pkg::WORD_W'(1);
            end
            if (k < cut) begin
                queue_pair(ssms_pkg::OP_COMPARE, w, w, idx, k == len - 1);
            end else if (k == cut) begin
                queue_pair(ssms_pkg::OP_COMPARE, w, w ^ flip, idx, k == len - 1);
            end else begin
                // past the break anything goes, equal words must not count
                queue_pair(ssms_pkg::OP_COMPARE, w,
                           ($urandom_range(0, 1) == 0) ? w : rand_word(), idx,
                           k == len - 1);
            end
            if ($urandom_range(0, 49) == 0) begin
                queue_pair(ssms_pkg::OP_CLEAR, rand_word(), rand_word(), pick_sector(),
                           1'($urandom()));
            end
        end
    endtask

    // expected result of one accepted item, if any
    task automatic track_suffix_match(input word_pair_t it);
        int unsigned bytes;
        int unsigned sc;
        sector_score_t r;
        if (it.operation == ssms_pkg::OP_CLEAR) begin
            best_by_sector[it.idx] = ssms_pkg::SCORE_ZERO;
            clears_sent++;
        end else begin
            pairs_sent++;
            if (run_unbroken) begin
                if (it.disk == it.pattern) begin
                    if (run_words < ssms_pkg::SECTOR_WORDS) run_words++;
                    if (it.pattern != '0) run_nonzero = 1'b1;
                end else begin
                    run_unbroken = 1'b0;
                end
            end
            if (it.last) begin
                bytes = run_nonzero ? run_words * ssms_pkg::WORD_BYTES : 0;
                sc = (bytes * int'(ssms_pkg::SCORE_FULL)) / ssms_pkg::SECTOR_BYTES;
                if (sc > int'(ssms_pkg::SCORE_FULL)) sc = int'(ssms_pkg::SCORE_FULL);
                if (ssms_pkg::SCORE_W'(sc) > best_by_sector[it.idx]) begin
                    best_by_sector[it.idx] = ssms_pkg::SCORE_W'(sc);
                end
                r.sector = it.idx;
                r.bytes = ssms_pkg::BYTES_W'(bytes);
                r.score = ssms_pkg::SCORE_W'(sc);
                r.best = best_by_sector[it.idx];
                r.full = (best_by_sector[it.idx] == ssms_pkg::SCORE_FULL);
                if (r.full) full_matches++;
                pending_scores.push_back(r);
                run_unbroken = 1'b1;
                run_words = 0;
                run_nonzero = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got_val);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) track_suffix_match(on_wire);
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || word_pairs_to_send.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    on_wire = word_pairs_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= on_wire.operation;
                    s_disk_word <= on_wire.disk;
                    s_target_word <= on_wire.pattern;
                    s_sector_index <= on_wire.idx;
                    s_last_word <= on_wire.last;
                    if ($urandom_range(0, 249) == 0) send_calm = !send_calm;
                    send_gap = send_calm ? 0 : idle_len();
                end
            end
        end
    end

    // monitor and result-side ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_scores.size() == 0) begin
                    $display("%0t: result for sector %0d with none expected",
                             $time, m_result_sector);
                    mismatches++;
                end else begin
                    want = pending_scores.pop_front();
                    check_field("result_sector", 16'(want.sector), 16'(m_result_sector));
                    check_field("match_bytes", 16'(want.bytes), 16'(m_match_bytes));
                    check_field("score", 16'(want.score), 16'(m_score));
                    check_field("best_score", 16'(want.best), 16'(m_best_score));
                    check_field("full_match", 16'(want.full), 16'(m_full_match));
                end
                results_checked++;
            end
            if (s_valid && !s_ready) input_stalls++;
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (!long_hold_done && results_checked >= 12) begin
                // long hold-off so the block backs up into its input
                ready_hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
                if (!recv_calm && $urandom_range(0, 99) < 25) ready_hold = idle_len();
            end
            m_ready <= (ready_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_scores.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [ssms_pkg::WORD_W-1:0] a;
        run_unbroken = 1'b1;
        run_words = 0;
        run_nonzero = 1'b0;
        foreach (best_by_sector[i]) best_by_sector[i] = ssms_pkg::SCORE_ZERO;
        hot_sectors[0] = '0;
        hot_sectors[1] = '1;
        hot_sectors[2] = ssms_pkg::IDX_W'(1);
        hot_sectors[3] = ssms_pkg::IDX_W'(ssms_pkg::PATTERN_SECTORS / 2);
        hot_sectors[4] = ssms_pkg::IDX_W'($urandom());
        hot_sectors[5] = ssms_pkg::IDX_W'($urandom());

        // one-word sectors: equal ones, mismatch, equal zero
        queue_pair(ssms_pkg::OP_COMPARE, '1, '1, '0, 1'b1);
        queue_pair(ssms_pkg::OP_COMPARE, '0, '1, '1, 1'b1);
        queue_pair(ssms_pkg::OP_COMPARE, '0, '0, '1, 1'b1);
        // clear items in the middle of a sector leave the run alone
        a = rand_word();
        queue_pair(ssms_pkg::OP_COMPARE, a, a, ssms_pkg::IDX_W'(5), 1'b0);
        queue_pair(ssms_pkg::OP_CLEAR, '1, '0, '1, 1'b1);
        a = rand_word();
        queue_pair(ssms_pkg::OP_COMPARE, a, a, ssms_pkg::IDX_W'(5), 1'b0);
        queue_pair(ssms_pkg::OP_CLEAR, '0, '1, '0, 1'b0);
        a = rand_word();
        queue_pair(ssms_pkg::OP_COMPARE, a, a, ssms_pkg::IDX_W'(5), 1'b1);
        // zero words count once a nonzero word joins the run
        for (int k = 0; k < 6; k++) begin
            queue_pair(ssms_pkg::OP_COMPARE, '0, '0, ssms_pkg::IDX_W'(1022), 1'b0);
        end
        queue_pair(ssms_pkg::OP_COMPARE, '1, '1, ssms_pkg::IDX_W'(1022), 1'b1);
        // equal word after the break does not count
        a = rand_word();
        queue_pair(ssms_pkg::OP_COMPARE, a, a, ssms_pkg::IDX_W'(1022), 1'b0);
        queue_pair(ssms_pkg::OP_COMPARE, a, ~a, ssms_pkg::IDX_W'(1022), 1'b0);
        queue_pair(ssms_pkg::OP_COMPARE, a, a, ssms_pkg::IDX_W'(1022), 1'b1);
        queue_pair(ssms_pkg::OP_CLEAR, '0, '0, ssms_pkg::IDX_W'(1022), 1'b0);

        while (items_queued < RANDOM_ITEMS || sectors_queued < MIN_SECTORS) begin
            queue_random_sector();
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_pairs_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d word pairs and %0d clears; checked %0d sector scores, %0d full",
                 pairs_sent, clears_sent, results_checked, full_matches);
        $display("input held off for %0d cycles, %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
